// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/b64sd_pkg.sv -----
// types and constants of the base64 stream decoder
`default_nettype none

package b64sd_pkg;

   // status codes reported with the last character
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // character codes of both alphabets
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;

   // sextet values of the range starts and the two symbols
   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_62         = 6'd62;
   localparam logic [5:0] SEXTET_63         = 6'd63;

   // reset value of the capacity register
   localparam logic [11:0] CAPACITY_RESET = 12'd64;

   // bits that one character adds and one byte takes
   localparam logic [3:0] BITS_PER_CHAR = 4'd6;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // classification of one input character
   typedef struct packed {
      logic       skip;    // filler character, ignored
      logic       valid;   // member of either alphabet
      logic [5:0] sextet;  // six-bit value when valid
   } char_class_type;

endpackage

`default_nettype wire

// ----- rtl/b64sd_char_decode.sv -----
// character classifier: maps a raw byte to its six-bit value or a skip flag
`default_nettype none

module b64sd_char_decode
   import b64sd_pkg::*;
(
   input  wire logic [7:0]     char_code,
   output char_class_type      char_class
);

   logic [7:0] offset;

   // range checks and offset into the range
   always_comb begin
      char_class = '0;
      offset     = '0;
      if (char_code == CH_EQUALS || char_code == CH_CR ||
          char_code == CH_LF || char_code == CH_SPACE) begin
         char_class.skip = 1'b1;
      end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
         offset            = char_code - CH_UPPER_A;
         char_class.valid  = 1'b1;
         char_class.sextet = offset[5:0];
      end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
         offset            = char_code - CH_LOWER_A;
         char_class.valid  = 1'b1;
         char_class.sextet = offset[5:0] + SEXTET_LOWER_BASE;
      end else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9) begin
         offset            = char_code - CH_DIGIT_0;
         char_class.valid  = 1'b1;
         char_class.sextet = offset[5:0] + SEXTET_DIGIT_BASE;
      end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
         char_class.valid  = 1'b1;
         char_class.sextet = SEXTET_62;
      end else if (char_code == CH_SLASH || char_code == CH_UNDER) begin
         char_class.valid  = 1'b1;
         char_class.sextet = SEXTET_63;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder.sv -----
// top level of the base64 stream decoder
`default_nettype none

// Base64 stream decoder. Takes one character per transfer on req_ (tlast marks
// the final character of a string) and gives decoded bytes on rsp_. Both the
// standard and the url-safe alphabet are accepted; '=', CR, LF and space are
// skipped. A result is sent when a byte is complete or on the last character,
// which also carries the status and the byte count of the string (tlast set);
// tuser flags whether tdata holds a byte. An invalid character or a byte past
// csr_data capacity latches an error and the rest of the string is ignored.
// Throughput is one character per clock unless a result is held by rsp_tready:
// the character goes into an input register, and the decode, the accumulator
// update and the capacity compare are combinational between that register and
// the result register, which drives rsp_tvalid. The capacity register is
// taken at any time and should be written between strings.

`include "assert_macros.svh"

module base64_stream_decoder
   import b64sd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   // configuration write
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [11:0] csr_data,     // out_capacity

   // character input
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_code
   input  wire logic        req_tlast,    // last_char

   // decoded output
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,    // [7:0] data_byte, [9:8] status,
                                          // [21:10] byte_total, [23:22] zero
   output      logic        rsp_tuser,    // has_byte
   output      logic        rsp_tlast     // done_res
);

   // capacity register
   logic [11:0] capacity_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_last_ff;

   // string state
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  pending_ff, pending_in;
   logic [11:0] count_ff, count_in;
   logic [1:0]  err_ff, err_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_has_byte_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_done_ff;
   logic [1:0]  rsp_status_ff;
   logic [11:0] rsp_total_ff;

   // datapath signals
   char_class_type char_class;
   logic [11:0]    acc_shift;
   logic [3:0]     pend_sum;
   logic [3:0]     pend_left;
   logic           got_byte;
   logic [7:0]     byte_val;
   logic           gen_result;
   logic           out_free;
   logic           advance;

   // checker terms
   logic           mid_result;
   logic           retire_last;
   logic           state_idle;

   assign csr_ready = 1'b1;

   // capacity register write
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // character classification
   b64sd_char_decode u_char_decode (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   // decode step: accumulate, emit a byte, check capacity, flag a bad character
   always_comb begin
      acc_in     = acc_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      got_byte   = 1'b0;
      byte_val   = '0;
      acc_shift  = {acc_ff[5:0], char_class.sextet};
      pend_sum   = pending_ff + BITS_PER_CHAR;
      pend_left  = pend_sum - BITS_PER_BYTE;
      if (err_ff == STATUS_OK && !char_class.skip) begin
         if (!char_class.valid) begin
            err_in = STATUS_BAD_CHAR;
         end else begin
            acc_in     = acc_shift;
            pending_in = pend_sum;
            if (pend_sum >= BITS_PER_BYTE) begin
               pending_in = pend_left;
               if (count_ff >= capacity_ff) begin
                  err_in = STATUS_OVERFLOW;
               end else begin
                  got_byte = 1'b1;
                  byte_val = 8'(acc_shift >> pend_left);
                  count_in = count_ff + 12'd1;
               end
            end
         end
      end
   end

   // handshake: an item without a result may retire while the output waits
   assign gen_result = got_byte || in_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!gen_result || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && gen_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // string state update
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         pending_ff <= '0;
         count_ff   <= '0;
         err_ff     <= STATUS_OK;
      end else if (advance) begin
         if (in_last_ff) begin
            acc_ff     <= '0;
            pending_ff <= '0;
            count_ff   <= '0;
            err_ff     <= STATUS_OK;
         end else begin
            acc_ff     <= acc_in;
            pending_ff <= pending_in;
            count_ff   <= count_in;
            err_ff     <= err_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && gen_result) begin
         rsp_has_byte_ff <= got_byte;
         rsp_byte_ff     <= byte_val;
         rsp_done_ff     <= in_last_ff;
         rsp_status_ff   <= in_last_ff ? err_in : STATUS_OK;
         rsp_total_ff    <= in_last_ff ? count_in : 12'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_status_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_has_byte_ff;
   assign rsp_tlast  = rsp_done_ff;

   // terms used by the checks below
   assign mid_result  = rsp_valid_ff && !rsp_done_ff;
   assign retire_last = advance && in_last_ff;
   assign state_idle  = count_ff == 12'd0 && err_ff == STATUS_OK && pending_ff == 4'd0;

   // pending bit count stays even and below one byte
   `ASSERT_IMPLIES(a_pending_range, clock, reset, 1'b1, !pending_ff[0] && pending_ff <= 4'd6)
   // a result that does not end a string always carries a byte
   `ASSERT_IMPLIES(a_mid_has_byte, clock, reset, mid_result, rsp_has_byte_ff)
   // report fields are zero except at the end of a string
   `ASSERT_IMPLIES(a_mid_no_report, clock, reset, mid_result, rsp_status_ff == STATUS_OK)
   `ASSERT_IMPLIES(a_mid_no_total, clock, reset, mid_result, rsp_total_ff == 12'd0)
   // string state is cleared after the last character retires
   `ASSERT_NEXT(a_clear_after_last, clock, reset, retire_last, state_idle)

endmodule

`default_nettype wire
